[hdl/csc_pkg.sv]
// Shared types and constants for the compressed-column matrix store.
// No dependencies; used by csc_mac, the top level and the bench.
`default_nettype none

package csc_pkg;

  // Store sizing
  localparam int MAX_EQUATIONS = 256;
  localparam int MAX_ENTRIES   = 4096;

  // Field widths
  localparam int COL_W   = 9;
  localparam int ROW_W   = 8;
  localparam int POS_W   = $clog2(MAX_ENTRIES);
  localparam int START_W = POS_W + 1;
  localparam int VAL_W   = 32;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;

  // Column start table
  localparam int CS_DEPTH = MAX_EQUATIONS + 1;
  localparam int CS_AW    = $clog2(CS_DEPTH);

  // APB map: one 32-bit register per word
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 1;
  localparam int APB_AW    = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_NUM_EQUATIONS = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET_START = 3'd0,
    KIND_SET_ROW   = 3'd1,
    KIND_CLEAR     = 3'd2,
    KIND_ADD       = 3'd3,
    KIND_READ      = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_RANGE  = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_LO,
    S_HI,
    S_SRD,
    S_SCMP,
    S_VAL,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[hdl/csc_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module csc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/csc_mac.sv]
// Scale-and-accumulate unit: Q16.16 product, round to nearest, saturating add.
// Depends on csc_pkg. Two register stages; the sum path is combinational.
`default_nettype none

module csc_mac
  import csc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic signed [VAL_W-1:0] entry_value,
  input  wire logic signed [VAL_W-1:0] scale_factor,
  input  wire logic signed [VAL_W-1:0] stored,
  output logic      signed [VAL_W-1:0] sum
);

  localparam int PROD_W = 2 * VAL_W;
  localparam int FRAC_W = VAL_W / 2;
  localparam int RND_W  = PROD_W - FRAC_W;
  localparam int SUM_W  = RND_W + 1;
  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(64'sd1 <<< (FRAC_W - 1));
  localparam logic signed [SUM_W-1:0]  SAT_HI   = SUM_W'({1'b0, {(VAL_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0]  SAT_LO   = -SAT_HI - SUM_W'(1);

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [RND_W-1:0]  rnd_r, rnd_nxt;
  logic signed [PROD_W-1:0] biased;
  logic signed [SUM_W-1:0]  wide;

  assign prod_nxt = PROD_W'(entry_value) * PROD_W'(scale_factor);
  assign biased   = prod_r + HALF_LSB;
  // arithmetic shift floors toward minus infinity
  assign rnd_nxt  = RND_W'(biased >>> FRAC_W);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    rnd_r  <= rnd_nxt;
  end

  assign wide = SUM_W'(rnd_r) + SUM_W'(stored);

  always_comb begin
    priority if (wide > SAT_HI) begin
      sum = VAL_W'(SAT_HI);
    end else if (wide < SAT_LO) begin
      sum = VAL_W'(SAT_LO);
    end else begin
      sum = VAL_W'(wide);
    end
  end

endmodule

`default_nettype wire

[hdl/sparse_csc_matrix_assembly.sv]
// Compressed-column sparse matrix store with scatter-add; top level.
// Add/read: DECODE, then LO and HI read the column span, then SRD and SCMP test one
//   row entry each until a hit, then VAL, DONE. Set start/row: DECODE, DONE.
// Clear: DECODE, CLEAR, DONE. One item at a time; row search and result stalls set the rate.
// Sync active-low reset; then all 4096 value-store positions are zeroed, no transfers.
// Depends on csc_pkg, csc_ram, csc_mac.
`default_nettype none

module sparse_csc_matrix_assembly
  import csc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [KIND_W-1:0]        in_kind,
  input  wire logic [COL_W-1:0]         in_column_number,
  input  wire logic [ROW_W-1:0]         in_row_number,
  input  wire logic [POS_W-1:0]         in_store_position,
  input  wire logic [START_W-1:0]       in_column_start,
  input  wire logic signed [VAL_W-1:0]  in_entry_value,
  input  wire logic signed [VAL_W-1:0]  in_scale_factor,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [STAT_W-1:0]             out_status,
  output logic signed [VAL_W-1:0]       out_read_value,
  // configuration (APB)
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_AW-1:0]        paddr,
  input  wire logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]             prdata,
  output logic                          pready
);

  localparam logic [COL_W:0]   MAX_SLOT   = (COL_W+1)'(MAX_EQUATIONS);
  localparam logic [COL_W-1:0] MAX_SIZE   = COL_W'(MAX_EQUATIONS);
  localparam logic [START_W-1:0] MAX_POS  = START_W'(MAX_ENTRIES);
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(MAX_ENTRIES - 1);

  // ------------------------------------------------------------------
  // Configuration register
  // ------------------------------------------------------------------
  logic [COL_W-1:0]     num_eq_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_NUM_EQUATIONS);
  assign prdata  = (reg_idx == REG_NUM_EQUATIONS) ? APB_DW'(num_eq_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_eq_r <= '0;
    end else if (cfg_wr) begin
      num_eq_r <= pwdata[COL_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // State and item registers
  // ------------------------------------------------------------------
  state_t                   state_r, state_nxt;
  kind_t                    kind_r;
  logic [COL_W-1:0]         col_r;
  logic [ROW_W-1:0]         row_r;
  logic [POS_W-1:0]         pos_r;
  logic [START_W-1:0]       start_r;
  logic signed [VAL_W-1:0]  val_r, fac_r;

  logic [START_W-1:0]       lo_r, lo_nxt;
  logic [START_W-1:0]       hi_r, hi_nxt;
  logic [START_W-1:0]       k_r, k_nxt;
  logic [POS_W-1:0]         cnt_r, cnt_nxt;
  logic                     clr_report_r, clr_report_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic signed [VAL_W-1:0]  res_value_r, res_value_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0]  out_value_r, out_value_nxt;

  // RAM ports
  logic                     cs_we;
  logic [CS_AW-1:0]         cs_raddr;
  logic [START_W-1:0]       cs_rdata;
  logic                     rn_we;
  logic [ROW_W-1:0]         rn_rdata;
  logic                     vs_we;
  logic [POS_W-1:0]         vs_waddr;
  logic [VAL_W-1:0]         vs_wdata;
  logic [VAL_W-1:0]         vs_rdata;
  logic signed [VAL_W-1:0]  mac_sum;

  // decode helpers
  logic [COL_W-1:0]         size;
  logic                     bad_start, bad_pos, bad_index, row_hit, scan_left, out_free;

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // effective matrix size, clipped to the table
  assign size      = (num_eq_r > MAX_SIZE) ? MAX_SIZE : num_eq_r;
  assign bad_start = ({1'b0, col_r} > MAX_SLOT) || (start_r > MAX_POS);
  assign bad_pos   = ({1'b0, pos_r} >= MAX_POS);
  assign bad_index = (col_r >= size) || (COL_W'(row_r) >= size);
  assign scan_left = (k_r < hi_r);
  assign row_hit   = (rn_rdata == row_r);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= kind_t'(in_kind);
      col_r   <= in_column_number;
      row_r   <= in_row_number;
      pos_r   <= in_store_position;
      start_r <= in_column_start;
      val_r   <= in_entry_value;
      fac_r   <= in_scale_factor;
    end
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    k_r         <= k_nxt;
    res_status_r <= res_status_nxt;
    res_value_r <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;   // zero the value store after reset
      cnt_r        <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Sequencer: next state
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (kind_r)
          KIND_CLEAR:           state_nxt = S_CLEAR;
          KIND_ADD, KIND_READ:  state_nxt = bad_index ? S_DONE : S_LO;
          default:              state_nxt = S_DONE;
        endcase
      end
      S_CLEAR: begin
        if (cnt_r == LAST_POS) state_nxt = clr_report_r ? S_DONE : S_IDLE;
      end
      S_LO:   state_nxt = S_HI;
      S_HI:   state_nxt = S_SRD;
      S_SRD:  state_nxt = scan_left ? S_SCMP : S_DONE;
      S_SCMP: state_nxt = row_hit ? S_VAL : S_SRD;
      S_VAL:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer: datapath controls
  // ------------------------------------------------------------------
  always_comb begin
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    k_nxt          = k_r;
    cnt_nxt        = cnt_r;
    clr_report_nxt = clr_report_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    cs_we          = 1'b0;
    rn_we          = 1'b0;
    vs_we          = 1'b0;
    vs_waddr       = k_r[POS_W-1:0];
    vs_wdata       = mac_sum;
    // start-table read: col in DECODE, col + 1 in LO
    cs_raddr       = (state_r == S_LO) ? CS_AW'(col_r + COL_W'(1)) : CS_AW'(col_r);

    unique case (state_r)
      S_DECODE: begin
        res_status_nxt = ST_DONE;
        res_value_nxt  = '0;
        unique case (kind_r)
          KIND_SET_START: begin
            if (bad_start) res_status_nxt = ST_RANGE;
            else cs_we = 1'b1;
          end
          KIND_SET_ROW: begin
            if (bad_pos) res_status_nxt = ST_RANGE;
            else rn_we = 1'b1;
          end
          KIND_CLEAR: begin
            cnt_nxt        = '0;
            clr_report_nxt = 1'b1;
          end
          KIND_ADD, KIND_READ: begin
            if (bad_index) res_status_nxt = ST_RANGE;
          end
          default: res_status_nxt = ST_RANGE;
        endcase
      end
      S_CLEAR: begin
        vs_we    = 1'b1;
        vs_waddr = cnt_r;
        vs_wdata = '0;
        cnt_nxt  = cnt_r + POS_W'(1);
      end
      S_LO: begin
        lo_nxt = cs_rdata;
      end
      S_HI: begin
        // column end clipped to the store size
        hi_nxt = (cs_rdata > MAX_POS) ? MAX_POS : cs_rdata;
        k_nxt  = lo_r;
      end
      S_SRD: begin
        if (!scan_left) res_status_nxt = ST_ABSENT;
      end
      S_SCMP: begin
        if (!row_hit) k_nxt = k_r + START_W'(1);
      end
      S_VAL: begin
        if (kind_r == KIND_READ) begin
          res_value_nxt = vs_rdata;
        end else begin
          vs_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Output register
  // ------------------------------------------------------------------
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_value_nxt  = res_value_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;

  // ------------------------------------------------------------------
  // Stores and arithmetic
  // ------------------------------------------------------------------
  csc_ram #(.WIDTH(START_W), .DEPTH(CS_DEPTH)) u_col_starts (
    .clk   (clk),
    .we    (cs_we),
    .waddr (CS_AW'(col_r)),
    .wdata (start_r),
    .raddr (cs_raddr),
    .rdata (cs_rdata)
  );

  csc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ENTRIES)) u_row_numbers (
    .clk   (clk),
    .we    (rn_we),
    .waddr (pos_r),
    .wdata (row_r),
    .raddr (k_r[POS_W-1:0]),
    .rdata (rn_rdata)
  );

  csc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_entry_values (
    .clk   (clk),
    .we    (vs_we),
    .waddr (vs_waddr),
    .wdata (vs_wdata),
    .raddr (k_r[POS_W-1:0]),
    .rdata (vs_rdata)
  );

  // rounded product is registered in prod_r and rnd_r before VAL is reached
  csc_mac u_mac (
    .clk          (clk),
    .entry_value  (val_r),
    .scale_factor (fac_r),
    .stored       (signed'(vs_rdata)),
    .sum          (mac_sum)
  );

`ifndef SYNTHESIS
  a_vs_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    vs_we |-> (state_r == S_CLEAR) || (state_r == S_VAL && kind_r == KIND_ADD))
    else $error("value store written outside clear or add");

  a_scan_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCMP) |-> (k_r < MAX_POS))
    else $error("row scan beyond store");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside DONE");

  a_no_transfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> (state_r == S_CLEAR) || !out_valid_r || $past(out_valid_r)
                             || (state_r == S_DONE) || (state_r == S_IDLE))
    else $error("unexpected result during clear");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking bench for the compressed-column sparse matrix store: directed
// tests, then randomized assembly phases, with results checked against a predictor.
// Depends on csc_pkg and the sparse_csc_matrix_assembly top level.

module tb_top;
  import csc_pkg::*;

  // Run limit, in time units (2 per clock)
  localparam int TIMEOUT_UNITS = 4_000_000;
  // Longest column scan allowed for random adds and reads
  localparam int SPAN_LIMIT    = 64;
  // Saturation bounds of a Q16.16 sum
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  // One input transfer and one result transfer
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [POS_W-1:0]   pos;
    logic [START_W-1:0] start;
    logic [VAL_W-1:0]   value;
    logic [VAL_W-1:0]   factor;
  } matrix_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  read_value;
  } matrix_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                       in_valid;
  logic                       in_ready;
  logic [KIND_W-1:0]          in_kind;
  logic [COL_W-1:0]           in_column_number;
  logic [ROW_W-1:0]           in_row_number;
  logic [POS_W-1:0]           in_store_position;
  logic [START_W-1:0]         in_column_start;
  logic signed [VAL_W-1:0]    in_entry_value;
  logic signed [VAL_W-1:0]    in_scale_factor;

  logic                       out_valid;
  logic                       out_ready;
  logic [STAT_W-1:0]          out_status;
  logic signed [VAL_W-1:0]    out_read_value;

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [APB_AW-1:0]          paddr;
  logic [APB_DW-1:0]          pwdata;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;

  sparse_csc_matrix_assembly DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_column_number  (in_column_number),
    .in_row_number     (in_row_number),
    .in_store_position (in_store_position),
    .in_column_start   (in_column_start),
    .in_entry_value    (in_entry_value),
    .in_scale_factor   (in_scale_factor),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #1 clk = ~clk;

  // ------------------------------------------------------------------
  // Predictor state: our own copy of the three stores and the register.
  // The *_set flags track which structure entries were ever written, so
  // that the stimulus never makes the block scan an unwritten entry.
  // ------------------------------------------------------------------
  logic [START_W-1:0]       start_tbl [CS_DEPTH];
  bit                       start_set [CS_DEPTH];
  logic [ROW_W-1:0]         row_tbl   [MAX_ENTRIES];
  bit                       row_set   [MAX_ENTRIES];
  logic signed [VAL_W-1:0]  value_tbl [MAX_ENTRIES];
  logic [COL_W-1:0]         num_eq;

  matrix_reply_t pending_replies [$];

  // Columns laid out by the current phase; random adds aim at these
  int laid_first;
  int laid_count;

  // steady: no idling on either side; stall_request: receiver hold-off
  bit steady;
  int stall_request;

  int items_sent, adds_sent, reads_sent, clears_sent, settings_used;
  int results_checked, fail_count;

  function automatic int eff_size();
    return (num_eq > MAX_EQUATIONS) ? MAX_EQUATIONS : int'(num_eq);
  endfunction

  // First store position of the column holding the row, or -1.
  // A span end past the store is clipped; a reversed span is empty.
  function automatic int find_row(int c, int r);
    int lo, hi;
    lo = start_tbl[c];
    hi = start_tbl[c + 1];
    if (hi > MAX_ENTRIES) hi = MAX_ENTRIES;
    for (int k = lo; k < hi; k++)
      if (row_tbl[k] == r) return k;
    return -1;
  endfunction

  // Works out the reply to one accepted item and updates the stores
  function automatic matrix_reply_t apply_matrix_item(matrix_item_t it);
    matrix_reply_t rep;
    int size, k;
    longint ent, fac, prod, rounded, total;
    rep.status     = ST_DONE;
    rep.read_value = '0;
    size = eff_size();
    case (it.kind)
      KIND_SET_START: begin
        if (it.col > MAX_EQUATIONS || it.start > MAX_ENTRIES) begin
          rep.status = ST_RANGE;
        end else begin
          start_tbl[it.col] = it.start;
          start_set[it.col] = 1'b1;
        end
      end
      KIND_SET_ROW: begin
        if (it.pos >= MAX_ENTRIES) begin
          rep.status = ST_RANGE;
        end else begin
          row_tbl[it.pos] = it.row;
          row_set[it.pos] = 1'b1;
        end
      end
      KIND_CLEAR: begin
        foreach (value_tbl[i]) value_tbl[i] = '0;
      end
      KIND_ADD, KIND_READ: begin
        if (it.col >= size || it.row >= size) begin
          rep.status = ST_RANGE;
        end else begin
          k = find_row(it.col, it.row);
          if (k < 0) begin
            rep.status = ST_ABSENT;
          end else if (it.kind == KIND_READ) begin
            rep.read_value = value_tbl[k];
          end else begin
            // Q32.32 product, round half up to Q16.16, saturating sum
            ent = $signed(it.value);
            fac = $signed(it.factor);
            prod = ent * fac;
            rounded = (prod + 64'sd32768) >>> 16;
            total = value_tbl[k];
            total = total + rounded;
            if (total > Q_MAX) total = Q_MAX;
            if (total < Q_MIN) total = Q_MIN;
            value_tbl[k] = total[VAL_W-1:0];
          end
        end
      end
      default: rep.status = ST_RANGE;
    endcase
    return rep;
  endfunction

  // A column is safe to add to or read when both of its start slots and
  // every row number within its span were written, and the scan is short
  function automatic bit col_usable(int c, int max_span);
    int lo, hi;
    if (!start_set[c] || !start_set[c + 1]) return 1'b0;
    lo = start_tbl[c];
    hi = start_tbl[c + 1];
    if (hi > MAX_ENTRIES) hi = MAX_ENTRIES;
    if (hi - lo > max_span) return 1'b0;
    for (int k = lo; k < hi; k++)
      if (!row_set[k]) return 1'b0;
    return 1'b1;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic matrix_item_t make_item(logic [KIND_W-1:0] kind, int col, int row,
                                             int pos, int start, logic [VAL_W-1:0] value,
                                             logic [VAL_W-1:0] factor);
    matrix_item_t it;
    it.kind   = kind;
    it.col    = col;
    it.row    = row;
    it.pos    = pos;
    it.start  = start;
    it.value  = value;
    it.factor = factor;
    return it;
  endfunction

  // Every field random; callers override what the kind uses
  function automatic matrix_item_t rand_fields();
    matrix_item_t it;
    it.kind   = $urandom;
    it.col    = $urandom;
    it.row    = $urandom;
    it.pos    = $urandom;
    it.start  = $urandom;
    it.value  = $urandom;
    it.factor = $urandom;
    return it;
  endfunction

  // Random item: mostly adds and reads on laid-out columns, some noise
  function automatic matrix_item_t random_item();
    matrix_item_t it;
    int r, q, size, c, lo, hi;
    it = rand_fields();
    size = eff_size();
    r = $urandom_range(0, 99);
    if (r < 86) begin
      it.kind = (r < 55) ? KIND_ADD : KIND_READ;
      c = (laid_count > 0) ? laid_first + $urandom_range(0, laid_count - 1) : 0;
      if (r >= 80 || size == 0 || laid_count == 0 || !col_usable(c, SPAN_LIMIT)) begin
        // column out of range: no structure lookup at all
        it.col = $urandom_range(size, (1 << COL_W) - 1);
      end else begin
        it.col = c;
        lo = start_tbl[c];
        hi = start_tbl[c + 1];
        if (hi > MAX_ENTRIES) hi = MAX_ENTRIES;
        q = $urandom_range(0, 9);
        if (q < 7 && hi > lo)
          it.row = row_tbl[$urandom_range(lo, hi - 1)];
        else if (q < 9 || size == MAX_EQUATIONS)
          it.row = $urandom_range(0, size - 1);
        else
          it.row = $urandom_range(size, (1 << ROW_W) - 1);
      end
      // moderate magnitudes mostly, full range now and then
      q = $urandom_range(0, 3);
      if (q != 0) begin
        it.value  = {{12{it.value[19]}}, it.value[19:0]};
        it.factor = {{14{it.factor[17]}}, it.factor[17:0]};
      end
      if ($urandom_range(0, 19) == 0) it.factor = '0;
    end else if (r < 90) begin
      it.kind = KIND_SET_START;
      if ($urandom_range(0, 2) == 0) begin
        it.col   = $urandom_range(0, MAX_EQUATIONS);
        it.start = $urandom_range(0, MAX_ENTRIES);
      end
    end else if (r < 94) begin
      it.kind = KIND_SET_ROW;
    end else if (r < 99) begin
      it.kind = $urandom_range(KIND_READ + 1, (1 << KIND_W) - 1);
    end else begin
      it.kind = KIND_CLEAR;
    end
    return it;
  endfunction

  // ------------------------------------------------------------------
  // Sender: one item per call. After the transfer, valid stays high so a
  // back-to-back item can follow; a gap or wait_idle lowers it in the
  // same time step as the transfer edge.
  // ------------------------------------------------------------------
  task automatic send_item(matrix_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= it.kind;
    in_column_number  <= it.col;
    in_row_number     <= it.row;
    in_store_position <= it.pos;
    in_column_start   <= it.start;
    in_entry_value    <= it.value;
    in_scale_factor   <= it.factor;
    do @(posedge clk); while (!in_ready);
    pending_replies.push_back(apply_matrix_item(it));
    items_sent++;
    if (it.kind == KIND_ADD)   adds_sent++;
    if (it.kind == KIND_READ)  reads_sent++;
    if (it.kind == KIND_CLEAR) clears_sent++;
  endtask

  // Drop valid and let every outstanding result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_num_equations(logic [COL_W-1:0] n);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_NUM_EQUATIONS, 2'b00};
    pwdata  <= APB_DW'(n);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    num_eq = n;
    settings_used++;
  endtask

  // Lays out a few adjacent columns over a contiguous run of store
  // positions: each column start, then that column's row numbers, then a closing start
  task automatic build_columns();
    int size, ncols, pos, len;
    matrix_item_t it;
    size = eff_size();
    laid_count = 0;
    if (size == 0) return;
    ncols = $urandom_range(1, (size < 12) ? size : 12);
    laid_first = $urandom_range(0, size - ncols);
    pos = $urandom_range(0, MAX_ENTRIES - ncols * 40 - 1);
    for (int c = 0; c <= ncols; c++) begin
      it = rand_fields();
      it.kind  = KIND_SET_START;
      it.col   = laid_first + c;
      it.start = pos;
      send_item(it);
      if (c < ncols) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
        for (int k = 0; k < len; k++) begin
          it = rand_fields();
          it.kind = KIND_SET_ROW;
          it.pos  = pos + k;
          // rows mostly in range, occasionally beyond it; repeats allowed
          it.row  = ($urandom_range(0, 7) != 0) ? $urandom_range(0, size - 1)
                                                : $urandom_range(0, (1 << ROW_W) - 1);
          send_item(it);
        end
        pos += len;
      end
    end
    laid_count = ncols;
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Register at reset value zero: every add or read is out of range.
  // Also the unused kind codes.
  task automatic test_reset_state();
    send_item(make_item(KIND_READ, 0, 0, 0, 0, '0, '0));
    send_item(make_item(KIND_ADD, (1 << COL_W) - 1, (1 << ROW_W) - 1, (1 << POS_W) - 1,
                        (1 << START_W) - 1, 32'h7FFF_FFFF, 32'h8000_0000));
    for (int k = KIND_READ + 1; k < (1 << KIND_W); k++)
      send_item(make_item(k, 0, 0, 0, 0, '0, '0));
  endtask

  // Start slot past the table, start value past the store, both at maximum
  task automatic test_structure_limits();
    send_item(make_item(KIND_SET_START, MAX_EQUATIONS + 1, 0, 0, 0, '0, '0));
    send_item(make_item(KIND_SET_START, 0, 0, 0, MAX_ENTRIES + 1, '0, '0));
    send_item(make_item(KIND_SET_START, (1 << COL_W) - 1, 0, 0, (1 << START_W) - 1, '0, '0));
  endtask

  // Three columns at the top of the store:
  //   col 0: rows 0, 2, 0 (row 0 repeated; first copy wins)
  //   col 1: rows 1, 2, 255, span ending at the last store position
  //   col 2: reversed span, so empty
  task automatic test_directed_assembly();
    int rows [6];
    rows = '{0, 2, 0, 1, 2, 255};
    wait_idle();
    write_num_equations(3);
    send_item(make_item(KIND_SET_START, 0, 0, 0, 4090, '0, '0));
    send_item(make_item(KIND_SET_START, 1, 0, 0, 4093, '0, '0));
    send_item(make_item(KIND_SET_START, 2, 0, 0, MAX_ENTRIES, '0, '0));
    send_item(make_item(KIND_SET_START, 3, 0, 0, 4090, '0, '0));
    for (int k = 0; k < 6; k++)
      send_item(make_item(KIND_SET_ROW, 0, rows[k], 4090 + k, 0, '0, '0));
    laid_first = 0;
    laid_count = 3;
    // 3.0 * 2.0, then half an LSB above and below zero
    send_item(make_item(KIND_ADD, 0, 0, 0, 0, 32'h0003_0000, 32'h0002_0000));
    send_item(make_item(KIND_ADD, 0, 0, 0, 0, 32'h0000_0001, 32'h0000_8000));
    send_item(make_item(KIND_ADD, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0000_8000));
    send_item(make_item(KIND_ADD, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0000_8001));
    send_item(make_item(KIND_READ, 0, 0, 0, 0, '0, '0));
    // saturation both ways
    send_item(make_item(KIND_ADD, 0, 2, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(make_item(KIND_READ, 0, 2, 0, 0, '0, '0));
    send_item(make_item(KIND_ADD, 1, 2, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(make_item(KIND_READ, 1, 2, 0, 0, '0, '0));
    // zero factor leaves the value alone
    send_item(make_item(KIND_ADD, 1, 1, 0, 0, 32'h1234_5678, '0));
    send_item(make_item(KIND_READ, 1, 1, 0, 0, '0, '0));
    // absent row, empty column, column and row out of range
    send_item(make_item(KIND_READ, 1, 0, 0, 0, '0, '0));
    send_item(make_item(KIND_ADD, 2, 1, 0, 0, 32'h0001_0000, 32'h0001_0000));
    send_item(make_item(KIND_READ, 3, 0, 0, 0, '0, '0));
    send_item(make_item(KIND_ADD, 0, 3, 0, 0, 32'h0001_0000, 32'h0001_0000));
    // clear wipes every value
    send_item(make_item(KIND_CLEAR, 0, 0, 0, 0, '0, '0));
    send_item(make_item(KIND_READ, 0, 0, 0, 0, '0, '0));
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_input_backpressure();
    steady = 1'b1;
    stall_request = 300;
    repeat (16) send_item(random_item());
    steady = 1'b0;
  endtask

  // Phases over several register settings, extremes included
  task automatic test_random_assembly();
    int plan [9];
    int n;
    plan = '{1, 256, 2, 0, 511, 0, 300, 255, 8};
    plan[3] = $urandom_range(3, 254);
    for (int p = 0; p < 9; p++) begin
      wait_idle();
      write_num_equations(plan[p]);
      build_columns();
      steady = (p % 3 == 1);
      n = (plan[p] == 0) ? 30 : 105;
      repeat (n) send_item(random_item());
      steady = 1'b0;
    end
  endtask

  // ------------------------------------------------------------------
  // Result side: random ready with gaps, plus the long hold-off on request
  // ------------------------------------------------------------------
  initial begin : result_sink
    int run, gap, hold;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_request > 0) begin
        hold = stall_request;
        stall_request = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        run = $urandom_range(1, 24);
        out_ready <= 1'b1;
        repeat (run) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Each result transfer is matched against the oldest expectation
  always @(posedge clk) begin
    matrix_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d value %h",
                               out_status, out_read_value));
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status)
          note_failure($sformatf("result %0d status: expected %0d, got %0d",
                                 results_checked, want.status, out_status));
        if (out_read_value !== want.read_value)
          note_failure($sformatf("result %0d read_value: expected %h, got %h",
                                 results_checked, want.read_value, out_read_value));
      end
      results_checked++;
    end
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_kind           <= '0;
    in_column_number  <= '0;
    in_row_number     <= '0;
    in_store_position <= '0;
    in_column_start   <= '0;
    in_entry_value    <= '0;
    in_scale_factor   <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    num_eq = '0;
    steady = 1'b0;
    stall_request = 0;
    laid_first = 0;
    laid_count = 0;
    foreach (value_tbl[i]) value_tbl[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // the block's clearing pass after reset holds in_ready low; the first
    // transfer simply waits for it
    test_reset_state();
    test_structure_limits();
    test_directed_assembly();
    test_input_backpressure();
    test_random_assembly();

    wait_idle();
    repeat (20) @(posedge clk);
    if (pending_replies.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_replies.size()));

    $display("Sent %0d items (%0d adds, %0d reads, %0d clears) over %0d register settings.",
             items_sent, adds_sent, reads_sent, clears_sent, settings_used);
    $display("Checked %0d results; %0d failures.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/csc_pkg.sv
hdl/csc_ram.sv
hdl/csc_mac.sv
hdl/sparse_csc_matrix_assembly.sv
tb/sv/tb_top.sv
